// File: design/tkd_pkg.sv
package tkd_pkg;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_TAIL,
        PH_PREFIX
    } phase_t;

    localparam logic [4:0] KEY_UNKNOWN = 5'd0;
    localparam logic [4:0] KEY_CHAR    = 5'd1;
    localparam logic [4:0] KEY_CTRL    = 5'd2;
    localparam logic [4:0] KEY_TAB     = 5'd3;
    localparam logic [4:0] KEY_BKSP    = 5'd4;
    localparam logic [4:0] KEY_ENTER   = 5'd5;
    localparam logic [4:0] KEY_ESC     = 5'd6;
    localparam logic [4:0] KEY_UP      = 5'd7;
    localparam logic [4:0] KEY_DOWN    = 5'd8;
    localparam logic [4:0] KEY_RIGHT   = 5'd9;
    localparam logic [4:0] KEY_LEFT    = 5'd10;
    localparam logic [4:0] KEY_DEL     = 5'd11;
    localparam logic [4:0] KEY_INS     = 5'd12;
    localparam logic [4:0] KEY_HOME    = 5'd13;
    localparam logic [4:0] KEY_END     = 5'd14;
    localparam logic [4:0] KEY_PGUP    = 5'd15;
    localparam logic [4:0] KEY_PGDN    = 5'd16;
    localparam logic [4:0] KEY_F1      = 5'd17;
    localparam logic [4:0] KEY_F12     = 5'd28;

    localparam logic [7:0] BYTE_NUL    = 8'd0;
    localparam logic [7:0] BYTE_BS     = 8'd8;
    localparam logic [7:0] BYTE_TAB    = 8'd9;
    localparam logic [7:0] BYTE_LF     = 8'd10;
    localparam logic [7:0] BYTE_CR     = 8'd13;
    localparam logic [7:0] BYTE_ESC    = 8'd27;
    localparam logic [7:0] BYTE_DEL    = 8'd127;
    localparam logic [7:0] BYTE_EXT    = 8'd224;

    localparam int VT_ENTRIES = 22;
    localparam int SEQ_KEEP   = 3;

    localparam logic [31:0] VT_SEQ [VT_ENTRIES] = '{
        32'h5B41_0000, 32'h5B42_0000, 32'h5B43_0000, 32'h5B44_0000,
        32'h5B33_7E00, 32'h5B32_7E00, 32'h5B48_0000, 32'h5B46_0000,
        32'h5B35_7E00, 32'h5B36_7E00,
        32'h4F50_0000, 32'h4F51_0000, 32'h4F52_0000, 32'h4F53_0000,
        32'h5B31_357E, 32'h5B31_377E, 32'h5B31_387E, 32'h5B31_397E,
        32'h5B32_307E, 32'h5B32_317E, 32'h5B32_337E, 32'h5B32_347E
    };

    localparam logic [2:0] VT_LEN [VT_ENTRIES] = '{
        3'd2, 3'd2, 3'd2, 3'd2, 3'd3, 3'd3, 3'd2, 3'd2, 3'd3, 3'd3,
        3'd2, 3'd2, 3'd2, 3'd2,
        3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4
    };

    localparam logic [4:0] VT_KEY [VT_ENTRIES] = '{
        KEY_UP, KEY_DOWN, KEY_RIGHT, KEY_LEFT, KEY_DEL, KEY_INS,
        KEY_HOME, KEY_END, KEY_PGUP, KEY_PGDN,
        KEY_F1, KEY_F1 + 5'd1, KEY_F1 + 5'd2, KEY_F1 + 5'd3,
        KEY_F1 + 5'd4, KEY_F1 + 5'd5, KEY_F1 + 5'd6, KEY_F1 + 5'd7,
        KEY_F1 + 5'd8, KEY_F1 + 5'd9, KEY_F1 + 5'd10, KEY_F12
    };

    typedef struct packed {
        logic       hit;
        logic [4:0] key;
        logic [6:0] ch;
    } key_res_t;

    function automatic logic [6:0] ctrl_letter(input logic [7:0] b);
        return b[6:0] + 7'd64;
    endfunction

    function automatic key_res_t vt_single(input logic [7:0] b);
        key_res_t r;
        r = '{hit: 1'b1, key: KEY_UNKNOWN, ch: 7'd0};
        priority if (b >= 8'd32 && b <= 8'd126)
        begin
            r.key = KEY_CHAR;
            r.ch  = b[6:0];
        end
        else if (b == BYTE_TAB)
            r.key = KEY_TAB;
        else if (b == BYTE_LF)
            r.key = KEY_ENTER;
        else if (b >= 8'd1 && b <= 8'd26)
        begin
            r.key = KEY_CTRL;
            r.ch  = ctrl_letter(b);
        end
        else if (b == BYTE_DEL)
            r.key = KEY_BKSP;
        else if (b == BYTE_ESC)
            r.hit = 1'b0;
        else
            r.key = KEY_UNKNOWN;
        return r;
    endfunction

    function automatic key_res_t con_single(input logic [7:0] b);
        key_res_t r;
        r = '{hit: 1'b1, key: KEY_UNKNOWN, ch: 7'd0};
        priority if (b >= 8'd32 && b <= 8'd126)
        begin
            r.key = KEY_CHAR;
            r.ch  = b[6:0];
        end
        else if (b == BYTE_TAB)
            r.key = KEY_TAB;
        else if (b == BYTE_BS)
            r.key = KEY_BKSP;
        else if (b == BYTE_CR)
            r.key = KEY_ENTER;
        else if (b == BYTE_ESC)
            r.key = KEY_ESC;
        else if (b >= 8'd1 && b <= 8'd26)
        begin
            r.key = KEY_CTRL;
            r.ch  = ctrl_letter(b);
        end
        else if (b == BYTE_NUL || b == BYTE_EXT)
            r.hit = 1'b0;
        else
            r.key = KEY_UNKNOWN;
        return r;
    endfunction

    function automatic logic [4:0] scan_key(input logic [7:0] s);
        logic [4:0] k;
        unique case (s)
            8'd72:   k = KEY_UP;
            8'd75:   k = KEY_LEFT;
            8'd77:   k = KEY_RIGHT;
            8'd80:   k = KEY_DOWN;
            8'd83:   k = KEY_DEL;
            8'd71:   k = KEY_HOME;
            8'd73:   k = KEY_PGUP;
            8'd79:   k = KEY_END;
            8'd81:   k = KEY_PGDN;
            8'd82:   k = KEY_INS;
            8'd133:  k = KEY_F1 + 5'd10;
            8'd134:  k = KEY_F12;
            default:
            begin
                if (s >= 8'd59 && s <= 8'd68)
                    k = KEY_F1 + 5'(s - 8'd59);
                else
                    k = KEY_UNKNOWN;
            end
        endcase
        return k;
    endfunction

    // len = 0 matches nothing; returns KEY_UNKNOWN on a miss
    function automatic logic [4:0] vt_lookup(input logic [2:0] len, input logic [31:0] seq);
        logic [4:0]  k;
        logic [31:0] mask;
        k = KEY_UNKNOWN;
        for (int i = VT_ENTRIES - 1; i >= 0; i--)
        begin
            mask = 32'hFFFF_FFFF << (6'd32 - {len, 3'b000});
            if (VT_LEN[i] == len && ((VT_SEQ[i] ^ seq) & mask) == 32'd0)
                k = VT_KEY[i];
        end
        return k;
    endfunction

endpackage

// File: design/terminal_key_decoder_top.sv
// Registered: a result appears on out_valid in the cycle after the byte beat that completes it.
// Throughput: one byte beat per cycle while in_ready is high; each byte is decoded in one
//   pass between the handshake and the result register, all sequence compares in parallel.
// in_ready stays high while the result register is empty or is being drained.
// Reset (rst_n low, asynchronous): VT mode, idle, empty tail, no result pending.
module terminal_key_decoder_top #(
    parameter int MAX_TAIL = 7
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] byte_in,
    input  logic       no_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [4:0] key_code,
    output logic [6:0] char_value
);
    import tkd_pkg::*;

    localparam int CW = $clog2(MAX_TAIL + 1);

    logic          mode_reg, mode_next;
    phase_t        phase_reg, phase_next;
    logic [CW-1:0] count_reg, count_next, count_inc;
    logic [7:0]    seq_reg [SEQ_KEEP];
    logic          seq_wr;
    logic          out_valid_reg, out_valid_next;
    logic [4:0]    key_reg;
    logic [6:0]    char_reg;

    logic          in_fire;
    logic          tail_full;
    logic [2:0]    match_len;
    logic [31:0]   cand;
    logic [4:0]    match_key;
    key_res_t      res;

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign count_inc = count_reg + CW'(1);
    assign tail_full = count_reg >= CW'(MAX_TAIL);

    always_comb
    begin
        for (int i = 0; i < SEQ_KEEP; i++)
        begin
            if (count_reg != CW'(i))
                cand[31 - 8*i -: 8] = seq_reg[i];
            else
                cand[31 - 8*i -: 8] = byte_in;
        end
        cand[7:0] = byte_in;
        match_len = (count_inc <= CW'(4)) ? count_inc[2:0] : 3'd0;
        match_key = vt_lookup(match_len, cand);
    end

    always_comb
    begin
        res = '{hit: 1'b0, key: KEY_UNKNOWN, ch: 7'd0};
        if (mode_reg)
        begin
            if (!no_byte)
            begin
                if (phase_reg == PH_PREFIX)
                    res = '{hit: 1'b1, key: scan_key(byte_in), ch: 7'd0};
                else
                    res = con_single(byte_in);
            end
        end
        else if (phase_reg == PH_TAIL)
        begin
            priority if (no_byte || tail_full)
                res = '{hit: 1'b1, key: KEY_ESC, ch: 7'd0};
            else if (match_key != KEY_UNKNOWN)
                res = '{hit: 1'b1, key: match_key, ch: 7'd0};
            else if (count_inc >= CW'(MAX_TAIL))
                res = '{hit: 1'b1, key: KEY_ESC, ch: 7'd0};
            else
                res.hit = 1'b0;
        end
        else if (no_byte)
            res = '{hit: 1'b1, key: KEY_UNKNOWN, ch: 7'd0};
        else
            res = vt_single(byte_in);
    end

    always_comb
    begin
        mode_next  = mode_reg;
        phase_next = phase_reg;
        count_next = count_reg;
        seq_wr     = 1'b0;
        if (in_fire)
        begin
            if (mode_reg)
            begin
                if (!no_byte)
                begin
                    count_next = '0;
                    if (phase_reg != PH_PREFIX && !res.hit)
                        phase_next = PH_PREFIX;
                    else
                        phase_next = PH_IDLE;
                end
            end
            else if (phase_reg == PH_TAIL)
            begin
                seq_wr = !no_byte && !tail_full;
                if (res.hit)
                begin
                    phase_next = PH_IDLE;
                    count_next = '0;
                end
                else
                    count_next = count_inc;
            end
            else
            begin
                count_next = '0;
                phase_next = (!no_byte && !res.hit) ? PH_TAIL : PH_IDLE;
            end
        end
        if (cfg_we)
        begin
            mode_next  = cfg_data;
            phase_next = PH_IDLE;
            count_next = '0;
        end
    end

    assign out_valid_next = in_ready ? (in_fire && res.hit) : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= 1'b0;
            phase_reg     <= PH_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            phase_reg     <= phase_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // hold only the bytes a sequence can still be compared on
    always_ff @(posedge clk)
    begin
        if (seq_wr && count_reg < CW'(SEQ_KEEP))
            seq_reg[count_reg[1:0]] <= byte_in;
        if (in_fire && res.hit)
        begin
            key_reg  <= res.key;
            char_reg <= res.ch;
        end
    end

    assign out_valid  = out_valid_reg;
    assign key_code   = key_reg;
    assign char_value = char_reg;

endmodule

// File: design/tkd_checker.sv
module tkd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       cfg_we,
    input logic       cfg_data,
    input logic       in_valid,
    input logic       in_ready,
    input logic [7:0] byte_in,
    input logic       no_byte,
    input logic       out_valid,
    input logic       out_ready,
    input logic [4:0] key_code,
    input logic [6:0] char_value
);
    import tkd_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(key_code) && $stable(char_value))
        else $error("result beat changed while stalled");

    a_key_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> key_code <= KEY_F12)
        else $error("key code out of range");

    a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && key_code != KEY_CHAR && key_code != KEY_CTRL |-> char_value == 7'd0)
        else $error("char value set on a non-character key");

    a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && key_code == KEY_CTRL |-> char_value >= 7'd65 && char_value <= 7'd90)
        else $error("ctrl letter out of range");

endmodule

bind terminal_key_decoder_top tkd_checker u_tkd_checker (.*);
